FILE: hw/rtl/amss_pkg.sv
`default_nettype none

package amss_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned GroupW    = 3;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned SlotW     = 5;
  localparam int unsigned CountW    = 16;
  localparam logic [SlotW-1:0] SlotDummy = 5'd13;

  typedef struct packed {
    logic               mode;
    logic [SampleW-1:0] adc_sample;
    logic [2:0]         lines_at_addr0;
    logic [2:0]         lines_at_addr1;
  } in_item_t;

  typedef struct packed {
    logic               tick_accepted;
    logic               tick_rejected;
    logic [5:0]         encoder_bits;
    logic [AddrW-1:0]   mux_address;
    logic               start_conversion;
    logic [1:0]         conversion_channel;
    logic               write_valid;
    logic [SlotW-1:0]   write_slot;
    logic [SampleW-1:0] write_value;
    logic [CountW-1:0]  overrun_total;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_SETTLE = 5'b00001,
    PH_CH1    = 5'b00010,
    PH_CH2    = 5'b00100,
    PH_CH0    = 5'b01000,
    PH_IDLE   = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    CHAN_0 = 2'd0,
    CHAN_1 = 2'd1,
    CHAN_2 = 2'd2
  } chan_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [SlotW-1:0] slot_ch0;
    logic [SlotW-1:0] slot_ch1;
    logic [SlotW-1:0] slot_ch2;
  } group_row_t;

  function automatic group_row_t group_row(input logic [GroupW-1:0] idx);
    group_row_t row;
    case (idx)
      3'd0:    row = '{addr: 3'd2, slot_ch0: 5'd0,  slot_ch1: 5'd1,  slot_ch2: 5'd2};
      3'd1:    row = '{addr: 3'd3, slot_ch0: 5'd3,  slot_ch1: 5'd4,  slot_ch2: 5'd5};
      3'd2:    row = '{addr: 3'd4, slot_ch0: 5'd6,  slot_ch1: 5'd7,  slot_ch2: 5'd8};
      3'd3:    row = '{addr: 3'd5, slot_ch0: 5'd9,  slot_ch1: 5'd10, slot_ch2: 5'd11};
      3'd4:    row = '{addr: 3'd6, slot_ch0: 5'd12, slot_ch1: 5'd13, slot_ch2: 5'd13};
      3'd5:    row = '{addr: 3'd7, slot_ch0: 5'd14, slot_ch1: 5'd15, slot_ch2: 5'd16};
      default: row = '{addr: 3'd0, slot_ch0: SlotDummy, slot_ch1: SlotDummy,
                       slot_ch2: SlotDummy};
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/amss_step.sv
`default_nettype none

module amss_step #(
  parameter int unsigned GROUP_COUNT = 6,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire amss_pkg::in_item_t  item_i,
  output amss_pkg::out_item_t      res_o
);

  localparam logic [amss_pkg::SampleW-1:0] SampleMask =
      amss_pkg::SampleW'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam logic [amss_pkg::GroupW:0] GroupLast = (amss_pkg::GroupW+1)'(GROUP_COUNT);
  localparam logic [amss_pkg::GroupW:0] GroupOne  = (amss_pkg::GroupW+1)'(1);
  localparam logic [amss_pkg::CountW-1:0] CountOne = (amss_pkg::CountW)'(1);

  amss_pkg::phase_e                 phase_q, phase_d;
  logic [amss_pkg::GroupW-1:0]      group_q, group_d;
  logic [amss_pkg::AddrW-1:0]       addr_q, addr_d;
  logic [amss_pkg::CountW-1:0]      overrun_q, overrun_d;

  amss_pkg::group_row_t             row;
  logic [amss_pkg::GroupW:0]        group_inc;
  logic [amss_pkg::SampleW-1:0]     sample;
  logic                             busy;

  assign row       = amss_pkg::group_row(group_q);
  assign group_inc = {1'b0, group_q} + GroupOne;
  assign sample    = item_i.adc_sample & SampleMask;
  assign busy      = (phase_q == amss_pkg::PH_CH1) || (phase_q == amss_pkg::PH_CH2) ||
                     (phase_q == amss_pkg::PH_CH0);

  always_comb begin
    phase_d   = phase_q;
    group_d   = group_q;
    addr_d    = addr_q;
    overrun_d = overrun_q;
    res_o     = '0;

    if (!item_i.mode) begin
      if (busy) begin
        res_o.tick_rejected = 1'b1;
        if (overrun_q != '1) begin
          overrun_d = overrun_q + CountOne;
        end
      end else begin
        res_o.tick_accepted      = 1'b1;
        res_o.encoder_bits       = {item_i.lines_at_addr1, item_i.lines_at_addr0};
        group_d                  = (group_inc >= GroupLast) ? '0 : group_inc[amss_pkg::GroupW-1:0];
        addr_d                   = amss_pkg::group_row(group_d).addr;
        phase_d                  = amss_pkg::PH_SETTLE;
        res_o.start_conversion   = 1'b1;
        res_o.conversion_channel = amss_pkg::CHAN_0;
      end
    end else begin
      case (phase_q)
        amss_pkg::PH_SETTLE: begin
          // drop the settling sample
          phase_d                  = amss_pkg::PH_CH1;
          res_o.start_conversion   = 1'b1;
          res_o.conversion_channel = amss_pkg::CHAN_1;
        end
        amss_pkg::PH_CH1: begin
          res_o.write_valid        = 1'b1;
          res_o.write_slot         = row.slot_ch1;
          res_o.write_value        = sample;
          phase_d                  = amss_pkg::PH_CH2;
          res_o.start_conversion   = 1'b1;
          res_o.conversion_channel = amss_pkg::CHAN_2;
        end
        amss_pkg::PH_CH2: begin
          res_o.write_valid        = 1'b1;
          res_o.write_slot         = row.slot_ch2;
          res_o.write_value        = sample;
          phase_d                  = amss_pkg::PH_CH0;
          res_o.start_conversion   = 1'b1;
          res_o.conversion_channel = amss_pkg::CHAN_0;
        end
        amss_pkg::PH_CH0: begin
          res_o.write_valid = 1'b1;
          res_o.write_slot  = row.slot_ch0;
          res_o.write_value = sample;
          phase_d           = amss_pkg::PH_IDLE;
          addr_d            = '0;
        end
        default: begin
          phase_d = amss_pkg::PH_IDLE;
        end
      endcase
    end

    res_o.mux_address   = addr_d;
    res_o.overrun_total = overrun_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= amss_pkg::PH_IDLE;
      group_q   <= '0;
      addr_q    <= '0;
      overrun_q <= '0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      group_q   <= group_d;
      addr_q    <= addr_d;
      overrun_q <= overrun_d;
    end
  end

`ifndef SYNTHESIS
  a_group_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      {1'b0, group_q} < GroupLast)
    else $error("group index out of range");

  a_reject_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      adv_i && !item_i.mode && busy |=> overrun_q != '0)
    else $error("rejected tick left overrun counter at zero");

  a_tick_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      adv_i && !item_i.mode && !busy |=> phase_q == amss_pkg::PH_SETTLE)
    else $error("accepted tick did not start settling conversion");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/amss_out_buf.sv
`default_nettype none

module amss_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire amss_pkg::out_item_t data_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output amss_pkg::out_item_t      out_data_o
);

  amss_pkg::out_item_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;
  logic                pop;

  assign ready_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
      push_i |-> ready_o)
    else $error("transfer pushed into full result buffer");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("result buffer pointers out of step with count");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/analog_mux_scan_sequencer.sv
// An input transfer is held in the input register, then the state update writes
// its result into a two-entry result buffer, from which it is transferred out.
// Throughput: one item per cycle; the result buffer keeps input open while one
// result waits, so a stalled output only blocks input once both entries fill.
// Reset (rst_ni low, asynchronous): phase idle, group 0, address 0, overrun
// count 0, input register and result buffer empty.
`default_nettype none

module analog_mux_scan_sequencer #(
  parameter int unsigned GROUP_COUNT = 6,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire amss_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output amss_pkg::out_item_t      out_data_o
);

  logic                 in_vld_q;
  amss_pkg::in_item_t   in_item_q;
  logic                 buf_ready;
  logic                 adv;
  amss_pkg::out_item_t  res;

  // advance the held item into the result buffer when there is room
  assign adv        = in_vld_q && buf_ready;
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
  end

  amss_step #(
    .GROUP_COUNT (GROUP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_item_q),
    .res_o  (res)
  );

  amss_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv),
    .data_i      (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/analog_mux_scan_sequencer_checker.sv
`timescale 1ns / 1ps

module analog_mux_scan_sequencer_checker #(
  parameter int unsigned GROUP_COUNT = 6,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  amss_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  amss_pkg::out_item_t           out_data_i,
  output int unsigned                   fails_o,
  output int unsigned                   backlog_o
);

  localparam logic ModeTick = 1'b0;

  // address and sensor slots of each scan group; groups past the sixth park on the dummy slot
  localparam amss_pkg::group_row_t SlotMap [8] = '{
    '{3'd2, 5'd0,               5'd1,               5'd2},
    '{3'd3, 5'd3,               5'd4,               5'd5},
    '{3'd4, 5'd6,               5'd7,               5'd8},
    '{3'd5, 5'd9,               5'd10,              5'd11},
    '{3'd6, 5'd12,              5'd13,              5'd13},
    '{3'd7, 5'd14,              5'd15,              5'd16},
    '{3'd0, amss_pkg::SlotDummy, amss_pkg::SlotDummy, amss_pkg::SlotDummy},
    '{3'd0, amss_pkg::SlotDummy, amss_pkg::SlotDummy, amss_pkg::SlotDummy}
  };

  amss_pkg::phase_e            phase_q;
  logic [amss_pkg::GroupW-1:0] group_q;
  logic [amss_pkg::AddrW-1:0]  addr_q;
  logic [amss_pkg::CountW-1:0] overruns_q;
  amss_pkg::out_item_t         results_due [$];
  int unsigned                 fails = 0;

  assign fails_o = fails;

  task automatic scan_step(input amss_pkg::in_item_t item, output amss_pkg::out_item_t res);
    int unsigned                  nxt;
    amss_pkg::group_row_t         row;
    logic [amss_pkg::SampleW-1:0] sample;
    row    = SlotMap[group_q];
    sample = (amss_pkg::SampleW)'(32'(item.adc_sample) & ((32'd1 << SAMPLE_BITS) - 32'd1));
    res    = '0;
    if (item.mode == ModeTick) begin
      if (phase_q inside {amss_pkg::PH_CH1, amss_pkg::PH_CH2, amss_pkg::PH_CH0}) begin
        // overrun: drop the tick, count it without wrapping
        res.tick_rejected = 1'b1;
        if (overruns_q != '1) overruns_q++;
      end else begin
        nxt = 32'(group_q) + 1;
        if (nxt >= GROUP_COUNT) nxt = 0;
        group_q                = (amss_pkg::GroupW)'(nxt);
        addr_q                 = SlotMap[group_q].addr;
        phase_q                = amss_pkg::PH_SETTLE;
        res.tick_accepted      = 1'b1;
        res.encoder_bits       = {item.lines_at_addr1, item.lines_at_addr0};
        res.start_conversion   = 1'b1;
        res.conversion_channel = amss_pkg::CHAN_0;
      end
    end else begin
      case (phase_q)
        amss_pkg::PH_SETTLE: begin
          phase_q                = amss_pkg::PH_CH1;
          res.start_conversion   = 1'b1;
          res.conversion_channel = amss_pkg::CHAN_1;
        end
        amss_pkg::PH_CH1: begin
          res.write_valid        = 1'b1;
          res.write_slot         = row.slot_ch1;
          res.write_value        = sample;
          phase_q                = amss_pkg::PH_CH2;
          res.start_conversion   = 1'b1;
          res.conversion_channel = amss_pkg::CHAN_2;
        end
        amss_pkg::PH_CH2: begin
          res.write_valid        = 1'b1;
          res.write_slot         = row.slot_ch2;
          res.write_value        = sample;
          phase_q                = amss_pkg::PH_CH0;
          res.start_conversion   = 1'b1;
          res.conversion_channel = amss_pkg::CHAN_0;
        end
        amss_pkg::PH_CH0: begin
          res.write_valid = 1'b1;
          res.write_slot  = row.slot_ch0;
          res.write_value = sample;
          phase_q         = amss_pkg::PH_IDLE;
          addr_q          = '0;
        end
        default: begin
          phase_q = amss_pkg::PH_IDLE;
        end
      endcase
    end
    res.mux_address   = addr_q;
    res.overrun_total = overruns_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    amss_pkg::out_item_t want;
    amss_pkg::out_item_t res;
    if (!rst_ni) begin
      phase_q    = amss_pkg::PH_IDLE;
      group_q    = '0;
      addr_q     = '0;
      overruns_q = '0;
      results_due.delete();
      backlog_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fails++;
        end else begin
          want = results_due.pop_front();
          check_field("tick_accepted", 32'(want.tick_accepted),
                      32'(out_data_i.tick_accepted));
          check_field("tick_rejected", 32'(want.tick_rejected),
                      32'(out_data_i.tick_rejected));
          check_field("encoder_bits", 32'(want.encoder_bits),
                      32'(out_data_i.encoder_bits));
          check_field("mux_address", 32'(want.mux_address),
                      32'(out_data_i.mux_address));
          check_field("start_conversion", 32'(want.start_conversion),
                      32'(out_data_i.start_conversion));
          check_field("conversion_channel", 32'(want.conversion_channel),
                      32'(out_data_i.conversion_channel));
          check_field("write_valid", 32'(want.write_valid),
                      32'(out_data_i.write_valid));
          check_field("write_slot", 32'(want.write_slot),
                      32'(out_data_i.write_slot));
          check_field("write_value", 32'(want.write_value),
                      32'(out_data_i.write_value));
          check_field("overrun_total", 32'(want.overrun_total),
                      32'(out_data_i.overrun_total));
        end
      end
      if (in_valid_i && in_ready_i) begin
        scan_step(in_data_i, res);
        results_due.push_back(res);
      end
      backlog_o <= results_due.size();
    end
  end

endmodule

FILE: tb/sv/analog_mux_scan_sequencer_test.sv
`timescale 1ns / 1ps

module analog_mux_scan_sequencer_test;

  localparam int unsigned GroupCount   = 6;
  localparam int unsigned SampleBits   = 12;
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned OverrunTicks = 20;
  localparam logic        ModeTick     = 1'b0;
  localparam logic        ModeDone     = 1'b1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  amss_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  amss_pkg::out_item_t out_data;
  int unsigned         fails;
  int unsigned         backlog;
  int unsigned         gap_pct    = 0;
  bit                  hold_req   = 1'b0;
  int unsigned         quiet      = 0;
  int unsigned         items_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  analog_mux_scan_sequencer #(
    .GROUP_COUNT(GroupCount),
    .SAMPLE_BITS(SampleBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  analog_mux_scan_sequencer_checker #(
    .GROUP_COUNT(GroupCount),
    .SAMPLE_BITS(SampleBits)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .fails_o    (fails),
    .backlog_o  (backlog)
  );

  function automatic amss_pkg::in_item_t tick_item(input logic [2:0] l0,
                                                   input logic [2:0] l1);
    amss_pkg::in_item_t it;
    it.mode           = ModeTick;
    it.adc_sample     = (amss_pkg::SampleW)'($urandom);
    it.lines_at_addr0 = l0;
    it.lines_at_addr1 = l1;
    return it;
  endfunction

  function automatic amss_pkg::in_item_t done_item(
      input logic [amss_pkg::SampleW-1:0] sample);
    amss_pkg::in_item_t it;
    it.mode           = ModeDone;
    it.adc_sample     = sample;
    it.lines_at_addr0 = 3'($urandom);
    it.lines_at_addr1 = 3'($urandom);
    return it;
  endfunction

  function automatic amss_pkg::in_item_t any_tick();
    return tick_item(3'($urandom), 3'($urandom));
  endfunction

  function automatic logic [amss_pkg::SampleW-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return (amss_pkg::SampleW)'($urandom);
  endfunction

  task automatic send(input amss_pkg::in_item_t item);
    bit taken;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // sample ready mid-cycle so the transfer decision is free of edge races
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic park();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic full_scan();
    send(any_tick());
    repeat (4) send(done_item(rand_sample()));
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned round;
    bit          held;
    bit          drained;
    held    = 1'b0;
    drained = 1'b0;
    round   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(done_item('1));               // conversion done while idle
    send(tick_item(3'd7, 3'd0));
    send(tick_item(3'd0, 3'd7));       // tick while settling restarts on the next group
    send(done_item(12'hABC));          // settling sample, discarded
    send(tick_item(3'd5, 3'd2));       // overrun on channel 1
    send(done_item('1));
    send(tick_item(3'd2, 3'd5));       // overrun on channel 2
    send(done_item('0));
    send(tick_item(3'd7, 3'd7));       // overrun on channel 0
    send(done_item(12'h800));
    send(done_item(12'h001));
    send(tick_item(3'd0, 3'd0));
    send(done_item(12'h7FF));

    while (items_sent < RandomItems) begin
      if (round % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 8;
          default: gap_pct = 30;
        endcase
      end
      round++;
      if (!held && items_sent > 400) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && items_sent > 700) begin
        drained = 1'b1;
        park();
        wait (backlog == 0);
        @(posedge clk);
      end
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        full_scan();
      end else if (kind < 16) begin
        send(any_tick());
        repeat ($urandom_range(0, 3)) send(done_item(rand_sample()));
      end else if (kind < 19) begin
        send(any_tick());
      end else begin
        send(done_item(rand_sample()));
      end
    end

    // end on a burst of overruns and a few clean scans, no idling from here on
    gap_pct = 0;
    repeat (4) send(done_item(rand_sample()));
    send(any_tick());
    send(done_item(rand_sample()));
    repeat (OverrunTicks) send(any_tick());
    repeat (3) send(done_item(rand_sample()));
    repeat (3) full_scan();

    park();
    wait (backlog == 0);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/amss_pkg.sv
hw/rtl/amss_step.sv
hw/rtl/amss_out_buf.sv
hw/rtl/analog_mux_scan_sequencer.sv
tb/sv/analog_mux_scan_sequencer_checker.sv
tb/sv/analog_mux_scan_sequencer_test.sv
